>>> sv/yrgb_pkg.sv
// Shared types, constants and a helper function of the YUV 4:2:0 to RGB888 converter.
package yrgb_pkg;

    // Default geometry limits.
    localparam int YRGB_MAX_WIDTH  = 4096;
    localparam int YRGB_MAX_HEIGHT = 4096;

    // Configuration port geometry.
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    // Limits are compared one bit wider than the register, so that 8192 fits.
    localparam int LIM_W     = CFG_W + 1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd1080;

    // Sample widths.
    localparam int SAMPLE_W = 8;
    localparam int CHROMA_W = 2 * SAMPLE_W;

    // BT.601 coefficients in 8.8 fixed point and the chroma offset.
    localparam logic signed [10:0] COEF_RV = 11'sd359;
    localparam logic signed [10:0] COEF_GU = 11'sd88;
    localparam logic signed [10:0] COEF_GV = 11'sd183;
    localparam logic signed [10:0] COEF_BU = 11'sd454;
    localparam logic signed [8:0]  CHROMA_OFS = 9'sd128;
    localparam logic signed [11:0] PIX_MAX    = 12'sd255;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    // Effective frame limits handed to the sequencer.
    typedef struct packed {
        logic [LIM_W-1:0] last_col;
        logic [LIM_W-1:0] last_line;
    } t_limits;

    // Pixel as it leaves the sequencer: luma, resolved chroma and position flags.
    typedef struct packed {
        logic [SAMPLE_W-1:0] luma;
        logic [CHROMA_W-1:0] chroma;
        logic                eol;
        logic                eof;
    } t_stage;

    // Floor division by 256 followed by saturation to 0..255.
    function automatic logic [SAMPLE_W-1:0] shift_sat(input logic signed [19:0] x);
        logic signed [11:0] q;
        q = x[19:8];
        if (q < 12'sd0) begin
            shift_sat = '0;
        end else if (q > PIX_MAX) begin
            shift_sat = 8'd255;
        end else begin
            shift_sat = q[SAMPLE_W-1:0];
        end
    endfunction

endpackage

>>> sv/yrgb_pix_if.sv
// Input channel carrying one YUV 4:2:0 pixel per transfer.
interface yrgb_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma;
    logic [7:0] blue_diff;
    logic [7:0] red_diff;

    modport source (output valid, output luma, output blue_diff, output red_diff,
                    input ready);
    modport sink   (input valid, input luma, input blue_diff, input red_diff,
                    output ready);
endinterface

>>> sv/yrgb_rgb_if.sv
// Output channel carrying one RGB888 pixel with line and frame markers per transfer.
interface yrgb_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       end_of_line;
    logic       end_of_frame;

    modport source (output valid, output red, output green, output blue,
                    output end_of_line, output end_of_frame, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input end_of_line, input end_of_frame, output ready);
endinterface

>>> sv/yuv420_planar_to_rgb888_core.sv
// Top level of the YUV 4:2:0 to RGB888 converter: configuration and frame limits.
//
// Converts a raster-order stream of 4:2:0 pixels to BT.601 RGB888 at one pixel per
// clock while the output is not stalled. A pixel is held first in the sequencer
// stage, where the chroma line store answers with its registered read and the
// colour arithmetic runs, and then in the output register, from which it leaves; a
// stall on the output holds it. While a finished pixel waits in the output register,
// one more pixel is still taken into the sequencer stage if that stage is empty. Even
// lines supply chroma at even columns; odd lines reuse it from a line store of
// MAX_WIDTH/2 entries, which needs no clearing after reset. Width and height are to
// be written through the configuration port while the block is idle, which it does
// not enforce. Out-of-range values are clamped; an odd width is rounded down to even.
module yuv420_planar_to_rgb888_core
    import yrgb_pkg::*;
#(
    parameter int MAX_WIDTH  = YRGB_MAX_WIDTH,
    parameter int MAX_HEIGHT = YRGB_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    yrgb_pix_if.sink             i_pix,
    yrgb_rgb_if.source           o_rgb
);

    localparam logic [LIM_W-1:0] MAX_W = LIM_W'(MAX_WIDTH);
    localparam logic [LIM_W-1:0] MAX_H = LIM_W'(MAX_HEIGHT);
    localparam logic [LIM_W-1:0] MIN_DIM = LIM_W'(2);

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [LIM_W-1:0] eff_width;
    logic [LIM_W-1:0] eff_height;
    t_limits          limits;
    t_stage           stage;
    logic             stage_valid;
    logic             take;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data;
                end
                REG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp the geometry and derive the last column and last line.
    always_comb begin
        eff_width  = {1'b0, r_frame_width};
        eff_height = {1'b0, r_frame_height};
        if (eff_width < MIN_DIM) begin
            eff_width = MIN_DIM;
        end else if (eff_width > MAX_W) begin
            eff_width = MAX_W;
        end
        eff_width = eff_width & ~LIM_W'(1);
        if (eff_height < MIN_DIM) begin
            eff_height = MIN_DIM;
        end else if (eff_height > MAX_H) begin
            eff_height = MAX_H;
        end
        limits.last_col  = eff_width - 1'b1;
        limits.last_line = eff_height - 1'b1;
    end

    yrgb_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_limits (limits),
        .i_pix    (i_pix),
        .i_take   (take),
        .o_valid  (stage_valid),
        .o_stage  (stage)
    );

    yrgb_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stage_valid),
        .i_stage (stage),
        .o_take  (take),
        .o_rgb   (o_rgb)
    );

endmodule

>>> sv/yrgb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module yrgb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data register holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/yrgb_seq.sv
// Raster counters, chroma selection and chroma line store in front of the colour stage.
module yrgb_seq
    import yrgb_pkg::*;
#(
    parameter int MAX_WIDTH  = YRGB_MAX_WIDTH,
    parameter int MAX_HEIGHT = YRGB_MAX_HEIGHT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_limits       i_limits,
    yrgb_pix_if.sink      i_pix,
    input  logic          i_take,
    output logic          o_valid,
    output t_stage        o_stage
);

    localparam int COL_W   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int LINE_W  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH   = MAX_WIDTH / 2;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [COL_W-1:0]    r_col, n_col;
    logic [LINE_W-1:0]   r_line, n_line;
    logic [CHROMA_W-1:0] r_held, n_held;
    logic                r_valid;
    logic [SAMPLE_W-1:0] r_luma;
    logic [CHROMA_W-1:0] r_chroma;
    logic                r_use_store;
    logic                r_eol;
    logic                r_eof;

    logic                advance;
    logic                accept;
    logic                even_line;
    logic                even_col;
    logic                store_wr;
    logic [ADDR_W-1:0]   slot;
    logic [CHROMA_W-1:0] in_chroma;
    logic [CHROMA_W-1:0] sel_chroma;
    logic [CHROMA_W-1:0] store_q;
    logic                eol;
    logic                eof;

    // The stage register moves on when it is empty or its content is taken.
    assign advance     = !r_valid || i_take;
    assign i_pix.ready = advance;
    assign accept      = i_pix.valid && advance;

    // Position decode.
    assign even_line = !r_line[0];
    assign even_col  = !r_col[0];
    assign slot      = ADDR_W'(r_col >> 1);
    assign in_chroma = {i_pix.blue_diff, i_pix.red_diff};
    assign store_wr  = accept && even_line && even_col;
    assign eol       = LIM_W'(r_col) >= i_limits.last_col;
    assign eof       = eol && (LIM_W'(r_line) >= i_limits.last_line);

    // Chroma on even lines comes from the transfer or the held pair.
    assign sel_chroma = even_col ? in_chroma : r_held;

    // Counter and held chroma update for an accepted pixel.
    always_comb begin
        n_col  = r_col;
        n_line = r_line;
        n_held = r_held;
        if (accept) begin
            if (store_wr) begin
                n_held = in_chroma;
            end
            if (eol) begin
                n_col  = '0;
                n_line = eof ? '0 : r_line + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_line  <= '0;
            r_held  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_line <= n_line;
            r_held <= n_held;
            if (advance) begin
                r_valid <= accept;
            end
        end
    end

    // Stage payload; odd lines take their chroma from the line store.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_luma      <= i_pix.luma;
            r_chroma    <= sel_chroma;
            r_use_store <= !even_line;
            r_eol       <= eol;
            r_eof       <= eof;
        end
    end

    // Chroma line store, one pair per two columns of an even line.
    yrgb_ram #(
        .WIDTH (CHROMA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_wr),
        .i_waddr (slot),
        .i_wdata (in_chroma),
        .i_re    (accept),
        .i_raddr (slot),
        .o_rdata (store_q)
    );

    assign o_valid        = r_valid;
    assign o_stage.luma   = r_luma;
    assign o_stage.chroma = r_use_store ? store_q : r_chroma;
    assign o_stage.eol    = r_eol;
    assign o_stage.eof    = r_eof;

endmodule

>>> sv/yrgb_conv.sv
// Fixed-point colour conversion with saturation and the output register.
module yrgb_conv
    import yrgb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_stage      i_stage,
    output logic        o_take,
    yrgb_rgb_if.source  o_rgb
);

    logic                r_valid;
    logic [SAMPLE_W-1:0] r_red, n_red;
    logic [SAMPLE_W-1:0] r_green, n_green;
    logic [SAMPLE_W-1:0] r_blue, n_blue;
    logic                r_eol;
    logic                r_eof;

    logic signed [8:0]  u;
    logic signed [8:0]  v;
    logic signed [19:0] yy;
    logic signed [19:0] p_rv;
    logic signed [19:0] p_gu;
    logic signed [19:0] p_gv;
    logic signed [19:0] p_bu;

    // The output register is free when empty or when its transfer completes.
    assign o_take = !r_valid || o_rgb.ready;

    // Remove the chroma offset and scale luma to 8.8.
    assign u  = $signed({1'b0, i_stage.chroma[CHROMA_W-1:SAMPLE_W]}) - CHROMA_OFS;
    assign v  = $signed({1'b0, i_stage.chroma[SAMPLE_W-1:0]}) - CHROMA_OFS;
    assign yy = $signed({4'b0, i_stage.luma, 8'b0});

    // One constant product per term.
    assign p_rv = v * COEF_RV;
    assign p_gu = u * COEF_GU;
    assign p_gv = v * COEF_GV;
    assign p_bu = u * COEF_BU;

    // Sum, floor shift and clamp for each colour.
    always_comb begin
        n_red   = shift_sat(yy + p_rv);
        n_green = shift_sat(yy - p_gu - p_gv);
        n_blue  = shift_sat(yy + p_bu);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_eol   <= i_stage.eol;
            r_eof   <= i_stage.eof;
        end
    end

    assign o_rgb.valid        = r_valid;
    assign o_rgb.red          = r_red;
    assign o_rgb.green        = r_green;
    assign o_rgb.blue         = r_blue;
    assign o_rgb.end_of_line  = r_eol;
    assign o_rgb.end_of_frame = r_eof;

endmodule

>>> sv/yrgb_chk.sv
// Port-level checks on the converter and the bind that attaches them.
module yrgb_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_red,
    input logic [7:0] i_green,
    input logic [7:0] i_blue,
    input logic       i_eol,
    input logic       i_eof
);

    // The end of a frame is always the end of a line.
    a_eof_on_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_eof |-> i_eol)
        else $error("end_of_frame without end_of_line");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // With the output register empty, the input side always takes a transfer.
    a_ready_when_empty: assert property (@(posedge i_clk)
        !i_out_valid |-> i_in_ready)
        else $error("input not ready while output is empty");

    // A stalled result keeps its contents.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_red)
            && $stable(i_green) && $stable(i_blue) && $stable(i_eol) && $stable(i_eof))
        else $error("stalled result changed");

endmodule

bind yuv420_planar_to_rgb888_core yrgb_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_red       (o_rgb.red),
    .i_green     (o_rgb.green),
    .i_blue      (o_rgb.blue),
    .i_eol       (o_rgb.end_of_line),
    .i_eof       (o_rgb.end_of_frame)
);
